// ----- rtl/core/m51pd_pkg.sv -----
package m51pd_pkg;

    localparam logic [4:0] MD_NO = 5'd0;
    localparam logic [4:0] MD_UN = 5'd1;
    localparam logic [4:0] MD_AC = 5'd2;
    localparam logic [4:0] MD_CF = 5'd3;
    localparam logic [4:0] MD_DP = 5'd4;
    localparam logic [4:0] MD_IM = 5'd5;
    localparam logic [4:0] MD_DI = 5'd6;
    localparam logic [4:0] MD_BI = 5'd7;
    localparam logic [4:0] MD_NB = 5'd8;
    localparam logic [4:0] MD_RG = 5'd9;
    localparam logic [4:0] MD_IS = 5'd10;
    localparam logic [4:0] MD_IF = 5'd11;
    localparam logic [4:0] MD_JF = 5'd12;
    localparam logic [4:0] MD_FO = 5'd13;
    localparam logic [4:0] MD_RO = 5'd14;
    localparam logic [4:0] MD_JP = 5'd15;
    localparam logic [4:0] MD_IX = 5'd16;
    localparam logic [4:0] MD_JX = 5'd17;
    localparam logic [4:0] MD_JR = 5'd18;

    localparam logic [7:0] OPC_MOV_DIR_DIR = 8'h85;
    localparam logic [7:0] OPC_UNDEFINED   = 8'hA5;
    localparam logic [2:0] CLS_OTHER       = 3'd0;
    localparam logic [2:0] CLS_JUMP        = 3'd1;
    localparam logic [2:0] CLS_CALL        = 3'd2;
    localparam logic [2:0] CLS_RETURN      = 3'd3;
    localparam logic [2:0] CLS_COND_JUMP   = 3'd4;
    localparam logic [2:0] CLS_UNKNOWN     = 3'd5;
    localparam logic [15:0] PAGE_HI_MASK   = 16'hF800;

    typedef struct packed {
        logic [5:0] mn;
        logic [4:0] m0;
        logic [4:0] m1;
        logic [4:0] m2;
    } op_entry_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] mnemonic;
        logic [2:0] iclass;
        logic [4:0] mode0;
        logic [4:0] mode1;
        logic [4:0] mode2;
    } dec_info_t;

    function automatic op_entry_t op_lookup(input logic [7:0] op);
        op_entry_t e;
        logic [3:0] hi;
        logic [3:0] lo;
        logic [5:0] alu;
        hi = op[7:4];
        lo = op[3:0];
        e = '{mn: 6'd0, m0: MD_NO, m1: MD_NO, m2: MD_NO};
        // columns 1: AJMP / ACALL alternate with the high nibble
        if (lo == 4'h1) begin
            e.mn = hi[0] ? 6'd28 : 6'd5;
            e.m0 = MD_JP;
        end else begin
            alu = 6'd0;
            unique case (hi)
                4'h0: alu = 6'd6;
                4'h1: alu = 6'd8;
                4'h2: alu = 6'd0;
                4'h3: alu = 6'd1;
                4'h4: alu = 6'd13;
                4'h5: alu = 6'd12;
                4'h6: alu = 6'd14;
                4'h9: alu = 6'd2;
                4'hB: alu = 6'd40;
                4'hC: alu = 6'd26;
                4'hD: alu = 6'd41;
                4'hE, 4'hF: alu = 6'd7;
                default: alu = 6'd7;
            endcase
            unique case (lo)
                4'h0: begin
                    unique case (hi)
                        4'h0: e = '{6'd42, MD_NO, MD_NO, MD_NO};
                        4'h1: e = '{6'd39, MD_BI, MD_JR, MD_NO};
                        4'h2: e = '{6'd37, MD_BI, MD_JR, MD_NO};
                        4'h3: e = '{6'd38, MD_BI, MD_JR, MD_NO};
                        4'h4: e = '{6'd35, MD_JR, MD_NO, MD_NO};
                        4'h5: e = '{6'd36, MD_JR, MD_NO, MD_NO};
                        4'h6: e = '{6'd33, MD_JR, MD_NO, MD_NO};
                        4'h7: e = '{6'd34, MD_JR, MD_NO, MD_NO};
                        4'h8: e = '{6'd3,  MD_JR, MD_NO, MD_NO};
                        4'h9: e = '{6'd7,  MD_DP, MD_IX, MD_NO};
                        4'hA: e = '{6'd13, MD_CF, MD_NB, MD_NO};
                        4'hB: e = '{6'd12, MD_CF, MD_NB, MD_NO};
                        4'hC: e = '{6'd24, MD_DI, MD_NO, MD_NO};
                        4'hD: e = '{6'd25, MD_DI, MD_NO, MD_NO};
                        4'hE: e = '{6'd23, MD_AC, MD_IF, MD_NO};
                        default: e = '{6'd23, MD_IF, MD_AC, MD_NO};
                    endcase
                end
                4'h2: begin
                    unique case (hi)
                        4'h0: e = '{6'd4,  MD_JX, MD_NO, MD_NO};
                        4'h1: e = '{6'd29, MD_JX, MD_NO, MD_NO};
                        4'h2: e = '{6'd30, MD_NO, MD_NO, MD_NO};
                        4'h3: e = '{6'd31, MD_NO, MD_NO, MD_NO};
                        4'h4: e = '{6'd13, MD_DI, MD_AC, MD_NO};
                        4'h5: e = '{6'd12, MD_DI, MD_AC, MD_NO};
                        4'h6: e = '{6'd14, MD_DI, MD_AC, MD_NO};
                        4'h7: e = '{6'd13, MD_CF, MD_BI, MD_NO};
                        4'h8: e = '{6'd12, MD_CF, MD_BI, MD_NO};
                        4'h9: e = '{6'd7,  MD_BI, MD_CF, MD_NO};
                        4'hA: e = '{6'd7,  MD_CF, MD_BI, MD_NO};
                        4'hB: e = '{6'd16, MD_BI, MD_NO, MD_NO};
                        4'hC: e = '{6'd15, MD_BI, MD_NO, MD_NO};
                        4'hD: e = '{6'd43, MD_BI, MD_NO, MD_NO};
                        default: e = '{6'd23, hi[0] ? MD_IS : MD_AC,
                                       hi[0] ? MD_AC : MD_IS, MD_NO};
                    endcase
                end
                4'h3: begin
                    unique case (hi)
                        4'h0: e = '{6'd19, MD_AC, MD_NO, MD_NO};
                        4'h1: e = '{6'd20, MD_AC, MD_NO, MD_NO};
                        4'h2: e = '{6'd17, MD_AC, MD_NO, MD_NO};
                        4'h3: e = '{6'd18, MD_AC, MD_NO, MD_NO};
                        4'h4: e = '{6'd13, MD_DI, MD_IM, MD_NO};
                        4'h5: e = '{6'd12, MD_DI, MD_IM, MD_NO};
                        4'h6: e = '{6'd14, MD_DI, MD_IM, MD_NO};
                        4'h7: e = '{6'd32, MD_JF, MD_NO, MD_NO};
                        4'h8: e = '{6'd22, MD_AC, MD_RO, MD_NO};
                        4'h9: e = '{6'd22, MD_AC, MD_FO, MD_NO};
                        4'hA: e = '{6'd6,  MD_DP, MD_NO, MD_NO};
                        4'hB: e = '{6'd16, MD_CF, MD_NO, MD_NO};
                        4'hC: e = '{6'd15, MD_CF, MD_NO, MD_NO};
                        4'hD: e = '{6'd43, MD_CF, MD_NO, MD_NO};
                        default: e = '{6'd23, hi[0] ? MD_IS : MD_AC,
                                       hi[0] ? MD_AC : MD_IS, MD_NO};
                    endcase
                end
                4'h4: begin
                    unique case (hi)
                        4'h0, 4'h1: e = '{alu, MD_AC, MD_NO, MD_NO};
                        4'h7: e = '{6'd7,  MD_AC, MD_IM, MD_NO};
                        4'h8: e = '{6'd10, MD_NO, MD_NO, MD_NO};
                        4'hA: e = '{6'd9,  MD_NO, MD_NO, MD_NO};
                        4'hB: e = '{6'd40, MD_AC, MD_IM, MD_JR};
                        4'hC: e = '{6'd21, MD_AC, MD_NO, MD_NO};
                        4'hD: e = '{6'd11, MD_AC, MD_NO, MD_NO};
                        4'hE: e = '{6'd15, MD_AC, MD_NO, MD_NO};
                        4'hF: e = '{6'd16, MD_AC, MD_NO, MD_NO};
                        default: e = '{alu, MD_AC, MD_IM, MD_NO};
                    endcase
                end
                4'h5: begin
                    unique case (hi)
                        4'h0, 4'h1: e = '{alu, MD_DI, MD_NO, MD_NO};
                        4'h7: e = '{6'd7,  MD_DI, MD_IM, MD_NO};
                        4'h8: e = '{6'd7,  MD_DI, MD_DI, MD_NO};
                        4'hA: e = '{6'd0,  MD_UN, MD_UN, MD_UN};
                        4'hB: e = '{6'd40, MD_AC, MD_DI, MD_JR};
                        4'hD: e = '{6'd41, MD_DI, MD_JR, MD_NO};
                        4'hE: e = '{6'd7,  MD_AC, MD_DI, MD_NO};
                        4'hF: e = '{6'd7,  MD_DI, MD_AC, MD_NO};
                        default: e = '{alu, MD_AC, MD_DI, MD_NO};
                    endcase
                end
                default: begin
                    // indirect and register columns share one pattern per row, except row D
                    logic [4:0] r;
                    r = lo[3] ? MD_RG : MD_IS;
                    unique case (hi)
                        4'h0, 4'h1: e = '{alu, r, MD_NO, MD_NO};
                        4'h7: e = '{6'd7,  r, MD_IM, MD_NO};
                        4'h8: e = '{6'd7,  MD_DI, r, MD_NO};
                        4'hA: e = '{6'd7,  r, MD_DI, MD_NO};
                        4'hB: e = '{6'd40, r, MD_IM, MD_JR};
                        4'hD: begin
                            if (lo[3]) begin
                                e = '{6'd41, r, MD_JR, MD_NO};
                            end else begin
                                e = '{6'd27, MD_AC, r, MD_NO};
                            end
                        end
                        4'hF: e = '{6'd7,  r, MD_AC, MD_NO};
                        default: e = '{alu, MD_AC, r, MD_NO};
                    endcase
                end
            endcase
        end
        return e;
    endfunction

    function automatic logic [2:0] class_lookup(input logic [5:0] mn);
        logic [2:0] c;
        unique case (mn)
            6'd3, 6'd4, 6'd5, 6'd32: c = CLS_JUMP;
            6'd28, 6'd29:            c = CLS_CALL;
            6'd30, 6'd31:            c = CLS_RETURN;
            6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41:
                                     c = CLS_COND_JUMP;
            default:                 c = CLS_OTHER;
        endcase
        return c;
    endfunction

    // code bytes one operand takes
    function automatic logic [1:0] mode_bytes(input logic [4:0] m);
        logic [1:0] n;
        unique case (m)
            MD_IM, MD_DI, MD_BI, MD_NB, MD_JP, MD_JR: n = 2'd1;
            MD_IX, MD_JX: n = 2'd2;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

// ----- rtl/core/m51pd_operand.sv -----
module m51pd_operand
    import m51pd_pkg::*;
(
    input  logic [4:0]  mode,
    input  logic [1:0]  pos,
    input  logic [15:0] pc,
    input  logic [7:0]  op,
    input  logic [7:0]  b1,
    input  logic [7:0]  b2,
    output logic [15:0] value
);
    logic [7:0]  bp;
    logic [7:0]  bq;
    logic [15:0] pc2;
    logic [15:0] rel_base;

    // select bytes at the current position and one past it
    always_comb begin
        case (pos)
            2'd1: bp = b1;
            2'd2: bp = b2;
            default: bp = 8'd0;
        endcase
        case (pos)
            2'd1: bq = b2;
            default: bq = 8'd0;
        endcase
    end

    assign pc2      = pc + 16'd2;
    assign rel_base = pc + {14'd0, pos} + 16'd1;

    always_comb begin
        case (mode)
            MD_IM, MD_DI, MD_BI, MD_NB: value = {8'd0, bp};
            MD_RG: value = {13'd0, op[2:0]};
            MD_IS: value = {15'd0, op[0]};
            MD_JP: value = (pc2 & PAGE_HI_MASK) | {5'd0, op[7:5], bp};
            MD_IX, MD_JX: value = {bp, bq};
            MD_JR: value = rel_base + {{8{bp[7]}}, bp};
            default: value = 16'd0;
        endcase
    end
endmodule

// ----- rtl/core/mcs51_instruction_predecode.sv -----
// MCS-51 instruction predecoder.
// Input channel (s_*): one request holds the instruction address and the
// opcode plus up to two following code bytes; accepted when s_valid and
// s_ready are both high. Output channel (m_*): one decoded result per
// request with mnemonic, class, three addressing modes, three operand
// values and the length in bytes.
// Pipeline of three register stages: table lookup, operand extraction,
// operand ordering into the output register, one request entering per
// cycle while the pipeline is not both full and stalled on m_ready.
// A stall on m_ready holds the output stage; s_ready drops only when the
// pipeline is full and the output is stalled, so nothing is lost or
// repeated. Each stage moves when the one after it is empty or moving.
// Reset (aresetn low, synchronous) empties every stage; payload registers
// keep stale data that is never shown.
module mcs51_instruction_predecode
    import m51pd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_pc,
    input  logic [7:0]  s_opcode_byte,
    input  logic [7:0]  s_second_byte,
    input  logic [7:0]  s_third_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic [5:0]  m_mnemonic,
    output logic [2:0]  m_instr_class,
    output logic [4:0]  m_mode_first,
    output logic [4:0]  m_mode_second,
    output logic [4:0]  m_mode_third,
    output logic [15:0] m_value_first,
    output logic [15:0] m_value_second,
    output logic [15:0] m_value_third,
    output logic [1:0]  m_length
);
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    // stage 1: table lookup
    dec_info_t   d1_reg, d1_next;
    logic [15:0] pc1_reg;
    logic [7:0]  op1_reg, b11_reg, b21_reg;
    // stage 2: operands extracted
    dec_info_t   d2_reg;
    logic [15:0] val0_reg, val1_reg, val2_reg;
    logic [1:0]  len2_reg;
    logic        swap2_reg;
    // stage 3: output

    op_entry_t   ent;
    logic [1:0]  pos0, pos1, pos2, pos3;
    logic [15:0] val0, val1, val2;

    assign adv3    = !v3_reg || m_ready;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    always_comb begin
        ent = op_lookup(s_opcode_byte);
        d1_next.ok       = (s_opcode_byte != OPC_UNDEFINED);
        d1_next.mnemonic = d1_next.ok ? ent.mn : 6'd0;
        d1_next.iclass   = d1_next.ok ? class_lookup(ent.mn) : CLS_UNKNOWN;
        d1_next.mode0    = d1_next.ok ? ent.m0 : MD_UN;
        // operand chain stops at the first absent mode
        d1_next.mode1    = (d1_next.ok && ent.m0 != MD_NO) ? ent.m1 : MD_NO;
        d1_next.mode2    = (d1_next.ok && ent.m0 != MD_NO && ent.m1 != MD_NO)
                           ? ent.m2 : MD_NO;
    end

    // byte positions of each operand
    assign pos0 = 2'd1;
    assign pos1 = pos0 + mode_bytes(d1_reg.mode0);
    assign pos2 = pos1 + mode_bytes(d1_reg.mode1);
    assign pos3 = pos2 + mode_bytes(d1_reg.mode2);

    m51pd_operand u_op0 (.mode(d1_reg.mode0), .pos(pos0), .pc(pc1_reg),
        .op(op1_reg), .b1(b11_reg), .b2(b21_reg), .value(val0));
    m51pd_operand u_op1 (.mode(d1_reg.mode1), .pos(pos1), .pc(pc1_reg),
        .op(op1_reg), .b1(b11_reg), .b2(b21_reg), .value(val1));
    m51pd_operand u_op2 (.mode(d1_reg.mode2), .pos(pos2), .pc(pc1_reg),
        .op(op1_reg), .b1(b11_reg), .b2(b21_reg), .value(val2));

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // advance payload
    always_ff @(posedge aclk) begin
        if (adv1) begin
            d1_reg  <= d1_next;
            pc1_reg <= s_pc;
            op1_reg <= s_opcode_byte;
            b11_reg <= s_second_byte;
            b21_reg <= s_third_byte;
        end
        if (adv2) begin
            d2_reg    <= d1_reg;
            len2_reg  <= d1_reg.ok ? pos3 : 2'd1;
            swap2_reg <= (op1_reg == OPC_MOV_DIR_DIR);
            val0_reg  <= d1_reg.ok ? val0 : 16'd0;
            val1_reg  <= d1_reg.ok ? val1 : 16'd0;
            val2_reg  <= d1_reg.ok ? val2 : 16'd0;
        end
        if (adv3) begin
            m_valid_res    <= d2_reg.ok;
            m_mnemonic     <= d2_reg.mnemonic;
            m_instr_class  <= d2_reg.iclass;
            m_mode_first   <= d2_reg.mode0;
            m_mode_second  <= d2_reg.mode1;
            m_mode_third   <= d2_reg.mode2;
            // swap operands of MOV direct,direct
            m_value_first  <= swap2_reg ? val1_reg : val0_reg;
            m_value_second <= swap2_reg ? val0_reg : val1_reg;
            m_value_third  <= val2_reg;
            m_length       <= len2_reg;
        end
    end

    assign m_valid = v3_reg;

`ifndef SYNTH
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_first))
        else $error("output changed under stall");
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_length != 2'd0)
        else $error("zero instruction length");
    a_invalid_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_length == 2'd1 && m_instr_class == CLS_UNKNOWN)
        else $error("bad undefined-opcode result");
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> v1_reg && v2_reg && v3_reg && !m_ready)
        else $error("ready dropped with room in pipeline");
`endif
endmodule
